@@ src/pidtv_pkg.sv @@
// Shared types, constants and microcode control word for the PID step block.
package pidtv_pkg;

  // Field widths
  localparam int ErrW   = 16;
  localparam int DtW    = 16;
  localparam int GainW  = 32;
  localparam int DriveW = 32;
  localparam int IntW   = 48;
  localparam int PcW    = 4;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegGainP = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 2'd2;

  typedef struct packed {
    logic signed [ErrW-1:0] error_sample;
    logic        [DtW-1:0]  elapsed_time;
    logic                   restart;
  } pidtv_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     saturated;
  } pidtv_out_t;

  // Multiplier operand selects
  typedef enum logic [1:0] {
    A_SUM,
    A_GP,
    A_GI,
    A_GD
  } pidtv_mul_a_e;

  typedef enum logic [2:0] {
    B_DT,
    B_ERR,
    B_ILO,
    B_IHI,
    B_DERIV
  } pidtv_mul_b_e;

  // Accumulator operations
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI,
    ACC_SHR
  } pidtv_acc_op_e;

  // Miscellaneous datapath operations
  typedef enum logic [2:0] {
    MISC_NONE,
    MISC_TAKE,
    MISC_DIV_INIT,
    MISC_INTEG,
    MISC_DIV_STEP,
    MISC_EMIT,
    MISC_CLEAR
  } pidtv_misc_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_RESTART,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } pidtv_cond_e;

  typedef struct packed {
    pidtv_mul_a_e  mul_a;
    pidtv_mul_b_e  mul_b;
    pidtv_acc_op_e acc_op;
    pidtv_misc_e   misc;
    pidtv_cond_e   cond;
    logic          last;
    logic [PcW-1:0] target;
  } pidtv_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic restart;
    logic cnt_nz;
    logic out_busy;
  } pidtv_flags_t;

endpackage

@@ src/pidtv_useq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
module pidtv_useq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pidtv_pkg::pidtv_flags_t flags_i,
  output pidtv_pkg::pidtv_ctrl_t  ctrl_o
);
  import pidtv_pkg::*;

  localparam logic [PcW-1:0] StepWait  = 4'd0;
  localparam logic [PcW-1:0] StepCheck = 4'd1;
  localparam logic [PcW-1:0] StepTrap  = 4'd2;
  localparam logic [PcW-1:0] StepInteg = 4'd3;
  localparam logic [PcW-1:0] StepDiv   = 4'd4;
  localparam logic [PcW-1:0] StepMil   = 4'd5;
  localparam logic [PcW-1:0] StepAil   = 4'd6;
  localparam logic [PcW-1:0] StepAih   = 4'd7;
  localparam logic [PcW-1:0] StepShr   = 4'd8;
  localparam logic [PcW-1:0] StepAp    = 4'd9;
  localparam logic [PcW-1:0] StepAd    = 4'd10;
  localparam logic [PcW-1:0] StepFin   = 4'd11;
  localparam logic [PcW-1:0] StepClr   = 4'd12;

  logic [PcW-1:0] pc_q, pc_d;
  pidtv_ctrl_t    ctrl;
  logic           jump;

  // Control store
  always_comb begin
    ctrl = '{mul_a: A_GP, mul_b: B_ERR, acc_op: ACC_HOLD, misc: MISC_NONE,
             cond: COND_NEVER, last: 1'b0, target: StepWait};
    case (pc_q)
      StepWait: begin
        ctrl.misc   = MISC_TAKE;
        ctrl.cond   = COND_NO_IN;
        ctrl.target = StepWait;
      end
      StepCheck: begin
        ctrl.cond   = COND_RESTART;
        ctrl.target = StepClr;
      end
      StepTrap: begin
        ctrl.mul_a = A_SUM;
        ctrl.mul_b = B_DT;
        ctrl.misc  = MISC_DIV_INIT;
      end
      StepInteg: begin
        ctrl.misc = MISC_INTEG;
      end
      StepDiv: begin
        ctrl.misc   = MISC_DIV_STEP;
        ctrl.cond   = COND_CNT_NZ;
        ctrl.target = StepDiv;
      end
      StepMil: begin
        ctrl.mul_a = A_GI;
        ctrl.mul_b = B_ILO;
      end
      StepAil: begin
        ctrl.mul_a  = A_GI;
        ctrl.mul_b  = B_IHI;
        ctrl.acc_op = ACC_LOAD;
      end
      StepAih: begin
        ctrl.acc_op = ACC_ADD_HI;
      end
      StepShr: begin
        ctrl.mul_a  = A_GP;
        ctrl.mul_b  = B_ERR;
        ctrl.acc_op = ACC_SHR;
      end
      StepAp: begin
        ctrl.mul_a  = A_GD;
        ctrl.mul_b  = B_DERIV;
        ctrl.acc_op = ACC_ADD;
      end
      StepAd: begin
        ctrl.acc_op = ACC_ADD;
      end
      StepFin: begin
        ctrl.misc   = MISC_EMIT;
        ctrl.cond   = COND_OUT_BUSY;
        ctrl.target = StepFin;
        ctrl.last   = 1'b1;
      end
      StepClr: begin
        ctrl.misc   = MISC_CLEAR;
        ctrl.cond   = COND_OUT_BUSY;
        ctrl.target = StepClr;
        ctrl.last   = 1'b1;
      end
      default: begin
        ctrl.last = 1'b1;
      end
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      COND_NO_IN:    jump = !flags_i.in_valid;
      COND_RESTART:  jump = flags_i.restart;
      COND_CNT_NZ:   jump = flags_i.cnt_nz;
      COND_OUT_BUSY: jump = flags_i.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    if (jump) begin
      pc_d = ctrl.target;
    end else if (ctrl.last) begin
      pc_d = StepWait;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

@@ src/pid_trapezoid_variable_dt.sv @@
// PID step with trapezoidal integral and variable time step, microcoded datapath.
//
//   channel  direction  handshake          word
//   in       input      in_valid/in_stall  error_sample, elapsed_time, restart
//   out      output     out_valid/out_stall drive, saturated
//   cfg      input      cfg_valid/ready    gain_p, gain_i, gain_d by index
//
// The block takes no new word until it has emitted the result of the last one,
// which needs a free output register; the derivative divider, stepped 16
// times at two quotient bits a step, does most of the work. A restart word skips it.
// One shared 32x33 multiplier serves every product. Reset clears the gains,
// the stored error and the integral. A stalled output holds the sequencer in
// its final step until the register is free.
module pid_trapezoid_variable_dt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pidtv_pkg::pidtv_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pidtv_pkg::pidtv_out_t                out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pidtv_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pidtv_pkg::GainW-1:0]          cfg_data_i
);
  import pidtv_pkg::*;

  localparam int SumW  = ErrW + 1;
  localparam int MulBW = GainW + 1;
  localparam int ProdW = GainW + MulBW;
  localparam int AccW  = 80;
  localparam int QuoW  = 32;

  pidtv_ctrl_t  ctrl;
  pidtv_flags_t flags;

  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [ErrW-1:0]  err_q, prev_q;
  logic [DtW-1:0]          dt_q;
  logic                    restart_q;
  logic signed [IntW-1:0]  integ_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [DtW-1:0]          rem_q, rem_d;
  logic [QuoW-1:0]         quo_q, quo_d;
  logic [3:0]              cnt_q;
  logic                    neg_q;
  logic                    sat_q;
  logic                    out_valid_q;
  pidtv_out_t              out_q;

  logic                    in_take, out_busy, emit;
  logic signed [SumW-1:0]  err_sum, err_diff;
  logic [SumW-1:0]         diff_mag;
  logic signed [GainW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulBW-1:0] deriv;
  logic signed [GainW-1:0] half;
  logic signed [IntW:0]    isum;
  logic signed [IntW-1:0]  integ_d;
  logic                    integ_sat;
  logic [DtW:0]            r1, r2;
  logic                    ge1, ge2;
  logic [DtW:0]            r1s, r2s;
  logic signed [63:0]      res;
  logic                    res_fits;
  logic signed [DriveW-1:0] drive;

  pidtv_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign in_take  = (ctrl.misc == MISC_TAKE);
  assign out_busy = out_valid_q && out_stall_i;
  assign emit     = ((ctrl.misc == MISC_EMIT) || (ctrl.misc == MISC_CLEAR)) && !out_busy;

  assign flags.in_valid = in_valid_i;
  assign flags.restart  = restart_q;
  assign flags.cnt_nz   = (cnt_q != 4'd0);
  assign flags.out_busy = out_busy;

  // Error sum and difference against the stored sample
  assign err_sum  = SumW'(err_q) + SumW'(prev_q);
  assign err_diff = SumW'(err_q) - SumW'(prev_q);
  assign diff_mag = err_diff[SumW-1] ? SumW'(-err_diff) : SumW'(err_diff);

  // Signed quotient, zero when no time has elapsed
  always_comb begin
    if (dt_q == '0) begin
      deriv = '0;
    end else if (neg_q) begin
      deriv = -$signed({1'b0, quo_q});
    end else begin
      deriv = $signed({1'b0, quo_q});
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctrl.mul_a)
      A_SUM:   mul_a = GainW'(err_sum);
      A_GP:    mul_a = gain_p_q;
      A_GI:    mul_a = gain_i_q;
      A_GD:    mul_a = gain_d_q;
      default: mul_a = gain_p_q;
    endcase
  end

  always_comb begin
    case (ctrl.mul_b)
      B_DT:    mul_b = $signed({{(MulBW-DtW){1'b0}}, dt_q});
      B_ERR:   mul_b = MulBW'(err_q);
      B_ILO:   mul_b = $signed({1'b0, integ_q[31:0]});
      B_IHI:   mul_b = MulBW'($signed(integ_q[IntW-1:32]));
      B_DERIV: mul_b = deriv;
      default: mul_b = MulBW'(err_q);
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Trapezoid step into the saturating integral
  assign half = prod_q[GainW:1];
  assign isum = (IntW+1)'(integ_q) + (IntW+1)'(half);
  always_comb begin
    integ_sat = 1'b0;
    integ_d   = isum[IntW-1:0];
    if (isum[IntW:IntW-1] == 2'b01) begin
      integ_d   = {1'b0, {(IntW-1){1'b1}}};
      integ_sat = 1'b1;
    end else if (isum[IntW:IntW-1] == 2'b10) begin
      integ_d   = {1'b1, {(IntW-1){1'b0}}};
      integ_sat = 1'b1;
    end
  end

  // Two restoring divide steps per cycle
  always_comb begin
    r1  = {rem_q, quo_q[QuoW-1]};
    ge1 = (r1 >= {1'b0, dt_q});
    r1s = ge1 ? (r1 - {1'b0, dt_q}) : r1;
    r2  = {r1s[DtW-1:0], quo_q[QuoW-2]};
    ge2 = (r2 >= {1'b0, dt_q});
    r2s = ge2 ? (r2 - {1'b0, dt_q}) : r2;
    rem_d = r2s[DtW-1:0];
    quo_d = {quo_q[QuoW-3:0], ge1, ge2};
  end

  // Accumulator
  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:   acc_d = AccW'(prod_q);
      ACC_ADD:    acc_d = acc_q + AccW'(prod_q);
      ACC_ADD_HI: acc_d = acc_q + (AccW'(prod_q) <<< 32);
      ACC_SHR:    acc_d = acc_q >>> 16;
      default:    acc_d = acc_q;
    endcase
  end

  // Final scale and clamp to the drive range
  assign res      = acc_q[AccW-1:16];
  assign res_fits = (&res[63:DriveW-1]) || !(|res[63:DriveW-1]);
  always_comb begin
    if (res_fits) begin
      drive = res[DriveW-1:0];
    end else if (res[63]) begin
      drive = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive = {1'b0, {(DriveW-1){1'b1}}};
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      prev_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegGainP: gain_p_q <= cfg_data_i;
          RegGainI: gain_i_q <= cfg_data_i;
          RegGainD: gain_d_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl.misc == MISC_INTEG) begin
        integ_q <= integ_d;
        prev_q  <= err_q;
      end else if (ctrl.misc == MISC_CLEAR) begin
        integ_q <= '0;
        prev_q  <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (in_take && in_valid_i) begin
      err_q     <= in_data_i.error_sample;
      dt_q      <= in_data_i.elapsed_time;
      restart_q <= in_data_i.restart;
    end
    if (ctrl.misc == MISC_DIV_INIT) begin
      rem_q <= '0;
      quo_q <= {diff_mag[DtW-1:0], {(QuoW-DtW){1'b0}}};
      neg_q <= err_diff[SumW-1];
      cnt_q <= 4'd15;
    end else if (ctrl.misc == MISC_DIV_STEP) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q - 4'd1;
    end
    if (ctrl.misc == MISC_INTEG) begin
      sat_q <= integ_sat;
    end
    if (emit) begin
      if (ctrl.misc == MISC_CLEAR) begin
        out_q.drive     <= '0;
        out_q.saturated <= 1'b0;
      end else begin
        out_q.drive     <= drive;
        out_q.saturated <= sat_q || !res_fits;
      end
    end
  end

  assign in_stall_o  = !in_take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

@@ src/pidtv_chk.sv @@
// Port checker for the PID step block and its bind statement.
module pidtv_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  pidtv_pkg::pidtv_out_t                out_data_o,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word dropped or changed");

  // Block goes busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous word still in work");

  // A new result only appears while the block is busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared with no word in work");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind pid_trapezoid_variable_dt pidtv_chk u_pidtv_chk (.*);
